[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a condition implies another one on the same clock edge.
`define ASSERT_SAME(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);
// Checks that a condition implies another one on the following clock edge.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);
`endif

[hw/rtl/rbi_pkg.sv]
package rbi_pkg;

   localparam int CoordWidth   = 32;
   localparam int DistWidth    = 32;
   localparam int NumAxes      = 3;
   localparam int NumFaces     = 6;
   localparam int NumRegs      = 6;
   localparam int DivSteps     = 2;
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;
   localparam int RegIdxWidth  = 3;

   // Register map: the three lower bounds come first, then the three upper bounds.
   localparam int BoxMinBase = 0;
   localparam int BoxMaxBase = 3;

   typedef struct packed {
      logic signed [CoordWidth-1:0] origin_x;
      logic signed [CoordWidth-1:0] origin_y;
      logic signed [CoordWidth-1:0] origin_z;
      logic signed [CoordWidth-1:0] dir_x;
      logic signed [CoordWidth-1:0] dir_y;
      logic signed [CoordWidth-1:0] dir_z;
   } req_word_type;

   typedef struct packed {
      logic                 hit;
      logic [DistWidth-1:0] distance;
   } rsp_word_type;

endpackage

[hw/rtl/rbi_mul.sv]
module rbi_mul #(
   parameter int OperandWidth = 33
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [OperandWidth-1:0]   a,
   input  logic signed [OperandWidth-1:0]   b,
   output logic signed [2*OperandWidth-1:0] product
);

   localparam int LoWidth  = (OperandWidth + 1) / 2;
   localparam int HiWidth  = OperandWidth - LoWidth;
   localparam int ProdWidth = 2 * OperandWidth;

   logic [OperandWidth-1:0]      mag_a;
   logic [OperandWidth-1:0]      mag_b;
   logic [2*LoWidth-1:0]         pp_ll_ff;
   logic [LoWidth+HiWidth-1:0]   pp_lh_ff;
   logic [LoWidth+HiWidth-1:0]   pp_hl_ff;
   logic [2*HiWidth-1:0]         pp_hh_ff;
   logic                         neg_ff;
   logic [ProdWidth-1:0]         sum;
   logic signed [ProdWidth-1:0]  product_in;
   logic signed [ProdWidth-1:0]  product_ff;

   // Magnitudes are split in halves so that each partial product stays narrow.
   assign mag_a = a[OperandWidth-1] ? OperandWidth'(-a) : OperandWidth'(a);
   assign mag_b = b[OperandWidth-1] ? OperandWidth'(-b) : OperandWidth'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ll_ff <= (2*LoWidth)'(mag_a[LoWidth-1:0]) * (2*LoWidth)'(mag_b[LoWidth-1:0]);
         pp_lh_ff <= (LoWidth+HiWidth)'(mag_a[LoWidth-1:0])
                     * (LoWidth+HiWidth)'(mag_b[OperandWidth-1:LoWidth]);
         pp_hl_ff <= (LoWidth+HiWidth)'(mag_a[OperandWidth-1:LoWidth])
                     * (LoWidth+HiWidth)'(mag_b[LoWidth-1:0]);
         pp_hh_ff <= (2*HiWidth)'(mag_a[OperandWidth-1:LoWidth])
                     * (2*HiWidth)'(mag_b[OperandWidth-1:LoWidth]);
         neg_ff   <= a[OperandWidth-1] ^ b[OperandWidth-1];
      end
   end

   always_comb begin
      sum = ProdWidth'(pp_ll_ff)
          + (ProdWidth'(pp_lh_ff) << LoWidth)
          + (ProdWidth'(pp_hl_ff) << LoWidth)
          + (ProdWidth'(pp_hh_ff) << (2 * LoWidth));
      product_in = neg_ff ? -signed'(sum) : signed'(sum);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

[hw/rtl/rbi_div.sv]
module rbi_div #(
   parameter int NumWidth = 32,
   parameter int FracBits = 16
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [NumWidth-1:0]            num,
   input  logic [NumWidth-1:0]            den,
   output logic [rbi_pkg::DistWidth-1:0]  quot
);

   localparam int QWidth      = rbi_pkg::DistWidth;
   localparam int NumStages   = QWidth / rbi_pkg::DivSteps;
   localparam int IntBits     = QWidth - FracBits;
   localparam int ScaledWidth = NumWidth + FracBits + QWidth;
   localparam int LimitWidth  = NumWidth + IntBits;

   logic [ScaledWidth-1:0] scaled;
   logic [NumWidth-1:0]    rem_ff [0:NumStages];
   logic [QWidth-1:0]      q_ff   [0:NumStages];
   logic [NumWidth-1:0]    den_ff [0:NumStages];
   logic                   ovf_ff [0:NumStages];
   logic [NumWidth-1:0]    rem_in [1:NumStages];
   logic [QWidth-1:0]      q_in   [1:NumStages];

   // The quotient overflows exactly when num >= den * 2^IntBits. Without
   // overflow the upper part of the scaled numerator is already below den,
   // so only the low QWidth bits need a step each.
   assign scaled = ScaledWidth'(num) << FracBits;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= NumWidth'(scaled >> QWidth);
         q_ff[0]   <= scaled[QWidth-1:0];
         den_ff[0] <= den;
         ovf_ff[0] <= LimitWidth'(num) >= (LimitWidth'(den) << IntBits);
      end
   end

   for (genvar s = 1; s <= NumStages; s++) begin : g_step
      always_comb begin
         logic [NumWidth:0]   trial;
         logic [NumWidth-1:0] r;
         logic [QWidth-1:0]   q;
         r = rem_ff[s-1];
         q = q_ff[s-1];
         for (int i = 0; i < rbi_pkg::DivSteps; i++) begin
            trial = {r, q[QWidth-1]};
            q = {q[QWidth-2:0], 1'b0};
            if (trial >= {1'b0, den_ff[s-1]}) begin
               trial = trial - {1'b0, den_ff[s-1]};
               q[0] = 1'b1;
            end
            r = trial[NumWidth-1:0];
         end
         rem_in[s] = r;
         q_in[s]   = q;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
            den_ff[s] <= den_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
   end

   assign quot = ovf_ff[NumStages] ? '1 : q_ff[NumStages];

endmodule

[hw/rtl/ray_box_intersect_core.sv]
// Ray against axis-aligned box intersection core.
// The box is held in six registers written over the APB-style port
// (lower x, y, z at byte addresses 0, 4, 8; upper x, y, z at 12, 16, 20),
// all signed Q16.16. A write is taken at the access cycle; reads return
// the stored bound, and addresses past the map read as zero.
// Each request word carries one ray (origin and direction, signed fixed
// point). Each response word carries a hit flag and the nearest distance
// t, unsigned with FRAC_BITS fraction bits, saturated to all ones; a miss
// gives distance zero.
// Throughput is one ray per clock while req_stall is low. The input register
// loads at the accepting edge; the word then passes the difference, two
// multiplier, compare, divider setup and divider registers, then the
// minimum and output registers. The restoring divider resolves two quotient
// bits per stage over 16 stages.
// Reset clears the box to zero and empties the pipeline.
// When the receiver stalls, the output word holds and one more word lands
// in a skid register; only then is req_stall raised, freezing the whole
// pipeline so nothing is lost or repeated.
`include "assert_macros.svh"

module ray_box_intersect_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rbi_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rbi_pkg::rsp_word_type               rsp_word,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rbi_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [rbi_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [rbi_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                pready
);

   localparam int Width      = rbi_pkg::CoordWidth;
   localparam int MulWidth   = Width + 1;
   localparam int NumFaces   = rbi_pkg::NumFaces;
   localparam int NumAxes    = rbi_pkg::NumAxes;
   localparam int DivStages  = rbi_pkg::DistWidth / rbi_pkg::DivSteps;

   // Stage numbering of the pipeline registers.
   localparam int StIn      = 0;
   localparam int StDiff    = 1;
   localparam int StPp      = 2;
   localparam int StProd    = 3;
   localparam int StCmp     = 4;
   localparam int StDiv0    = 5;
   localparam int StDivEnd  = StDiv0 + DivStages;
   localparam int StMin     = StDivEnd + 1;

   // ------------------------------------------------------------------
   // Box registers.
   // ------------------------------------------------------------------
   logic signed [Width-1:0]          box_ff [rbi_pkg::NumRegs];
   logic [rbi_pkg::RegIdxWidth-1:0]  reg_idx;
   logic                             reg_hit;

   assign reg_idx = paddr[rbi_pkg::CsrAddrWidth-1:2];
   assign reg_hit = reg_idx < rbi_pkg::NumRegs;
   assign pready  = 1'b1;
   assign prdata  = reg_hit ? rbi_pkg::CsrDataWidth'(box_ff[reg_idx]) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rbi_pkg::NumRegs; i++) begin
            box_ff[i] <= '0;
         end
      end else if (psel && penable && pwrite && reg_hit) begin
         box_ff[reg_idx] <= Width'(pwdata);
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control. Every stage moves together; the pipeline only
   // freezes while the skid register holds a word.
   // ------------------------------------------------------------------
   logic                  adv;
   logic                  v_ff [StIn:StMin];
   logic                  rsp_valid_ff;
   logic                  skid_v_ff;
   rbi_pkg::rsp_word_type rsp_word_ff;
   rbi_pkg::rsp_word_type skid_word_ff;
   rbi_pkg::rsp_word_type rsp_new;
   logic                  take;
   logic                  new_word;

   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = StIn; s <= StMin; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[StIn] <= req_valid;
         for (int s = StIn + 1; s <= StMin; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Input register.
   // ------------------------------------------------------------------
   logic signed [Width-1:0] o_ff [NumAxes];
   logic signed [Width-1:0] d_ff [NumAxes];

   always_ff @(posedge clock) begin
      if (adv) begin
         o_ff[0] <= req_word.origin_x;
         o_ff[1] <= req_word.origin_y;
         o_ff[2] <= req_word.origin_z;
         d_ff[0] <= req_word.dir_x;
         d_ff[1] <= req_word.dir_y;
         d_ff[2] <= req_word.dir_z;
      end
   end

   // ------------------------------------------------------------------
   // Differences to the bounds and face selection. Face 2k is the lower
   // face of axis k, face 2k+1 the upper one. For a tried face, n is the
   // distance to the face along its axis and dd the speed toward it.
   // ------------------------------------------------------------------
   logic signed [Width:0]   lom_in  [NumAxes];
   logic signed [Width:0]   him_in  [NumAxes];
   logic                    inside_in;
   logic [NumFaces-1:0]     tried_in;
   logic [Width-1:0]        n_in    [NumFaces];
   logic [Width-1:0]        dd_in   [NumFaces];

   logic signed [Width:0]   lom_ff  [NumAxes];
   logic signed [Width:0]   him_ff  [NumAxes];
   logic signed [Width-1:0] dax_ff  [NumAxes];
   logic [NumFaces-1:0]     tried_ff [StDiff:StProd];
   logic [Width-1:0]        n_ff    [StDiff:StCmp][NumFaces];
   logic [Width-1:0]        dd_ff   [StDiff:StCmp][NumFaces];
   logic                    inside_ff [StDiff:StDivEnd];

   always_comb begin
      logic signed [Width-1:0] lo;
      logic signed [Width-1:0] hi;
      logic signed [Width:0]   neg_d;
      inside_in = 1'b1;
      for (int k = 0; k < NumAxes; k++) begin
         lo = box_ff[rbi_pkg::BoxMinBase + k];
         hi = box_ff[rbi_pkg::BoxMaxBase + k];
         lom_in[k] = MulWidth'(lo) - MulWidth'(o_ff[k]);
         him_in[k] = MulWidth'(hi) - MulWidth'(o_ff[k]);
         neg_d     = -MulWidth'(d_ff[k]);
         inside_in = inside_in && (o_ff[k] > lo) && (o_ff[k] < hi);
         tried_in[2*k]   = (o_ff[k] <= lo) && (d_ff[k] > 0);
         tried_in[2*k+1] = (o_ff[k] >= hi) && (d_ff[k] < 0);
         n_in[2*k]    = lom_in[k][Width-1:0];
         dd_in[2*k]   = d_ff[k];
         n_in[2*k+1]  = Width'(-him_in[k]);
         dd_in[2*k+1] = neg_d[Width-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NumAxes; k++) begin
            lom_ff[k] <= lom_in[k];
            him_ff[k] <= him_in[k];
            dax_ff[k] <= d_ff[k];
         end
         tried_ff[StDiff]  <= tried_in;
         inside_ff[StDiff] <= inside_in;
         for (int f = 0; f < NumFaces; f++) begin
            n_ff[StDiff][f]  <= n_in[f];
            dd_ff[StDiff][f] <= dd_in[f];
         end
         for (int s = StDiff + 1; s <= StProd; s++) begin
            tried_ff[s] <= tried_ff[s-1];
         end
         for (int s = StDiff + 1; s <= StCmp; s++) begin
            for (int f = 0; f < NumFaces; f++) begin
               n_ff[s][f]  <= n_ff[s-1][f];
               dd_ff[s][f] <= dd_ff[s-1][f];
            end
         end
         for (int s = StDiff + 1; s <= StDivEnd; s++) begin
            inside_ff[s] <= inside_ff[s-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Cross products for the hit point test. On each other axis a, the hit
   // point lies within the bounds when
   //   (lo_a - o_a) * dd <= d_a * n <= (hi_a - o_a) * dd.
   // The products are exact, so no rounding enters the test.
   // ------------------------------------------------------------------
   logic signed [2*MulWidth-1:0] prod [NumFaces][2][3];

   for (genvar f = 0; f < NumFaces; f++) begin : g_face
      for (genvar j = 0; j < 2; j++) begin : g_axis
         localparam int Ax = ((f / 2) + 1 + j) % NumAxes;
         logic signed [MulWidth-1:0] dd_s;
         logic signed [MulWidth-1:0] n_s;

         assign dd_s = signed'({1'b0, dd_ff[StDiff][f]});
         assign n_s  = signed'({1'b0, n_ff[StDiff][f]});

         rbi_mul #(.OperandWidth(MulWidth)) u_mul_lo (
            .clock   (clock),
            .en      (adv),
            .a       (lom_ff[Ax]),
            .b       (dd_s),
            .product (prod[f][j][0])
         );

         rbi_mul #(.OperandWidth(MulWidth)) u_mul_mid (
            .clock   (clock),
            .en      (adv),
            .a       (MulWidth'(dax_ff[Ax])),
            .b       (n_s),
            .product (prod[f][j][1])
         );

         rbi_mul #(.OperandWidth(MulWidth)) u_mul_hi (
            .clock   (clock),
            .en      (adv),
            .a       (him_ff[Ax]),
            .b       (dd_s),
            .product (prod[f][j][2])
         );
      end
   end

   logic [NumFaces-1:0] ok_in;
   logic [NumFaces-1:0] acc_ff [StCmp:StDivEnd];

   always_comb begin
      for (int f = 0; f < NumFaces; f++) begin
         ok_in[f] = tried_ff[StProd][f];
         for (int j = 0; j < 2; j++) begin
            if ((prod[f][j][0] > prod[f][j][1]) || (prod[f][j][1] > prod[f][j][2])) begin
               ok_in[f] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_ff[StCmp] <= ok_in;
         for (int s = StCmp + 1; s <= StDivEnd; s++) begin
            acc_ff[s] <= acc_ff[s-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // One divider per face; the faces that were not accepted are dropped
   // at the minimum stage.
   // ------------------------------------------------------------------
   logic [rbi_pkg::DistWidth-1:0] t_face [NumFaces];

   for (genvar f = 0; f < NumFaces; f++) begin : g_div
      rbi_div #(.NumWidth(Width), .FracBits(FRAC_BITS)) u_div (
         .clock (clock),
         .en    (adv),
         .num   (n_ff[StCmp][f]),
         .den   (dd_ff[StCmp][f]),
         .quot  (t_face[f])
      );
   end

   // ------------------------------------------------------------------
   // Nearest accepted face: pairs first, then the three survivors.
   // ------------------------------------------------------------------
   logic                          pv_ff [3];
   logic [rbi_pkg::DistWidth-1:0] pt_ff [3];
   logic                          inside_min_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < 3; p++) begin
            pv_ff[p] <= acc_ff[StDivEnd][2*p] || acc_ff[StDivEnd][2*p+1];
            if (acc_ff[StDivEnd][2*p] &&
                (!acc_ff[StDivEnd][2*p+1] || (t_face[2*p] <= t_face[2*p+1]))) begin
               pt_ff[p] <= t_face[2*p];
            end else begin
               pt_ff[p] <= t_face[2*p+1];
            end
         end
         inside_min_ff <= inside_ff[StDivEnd];
      end
   end

   always_comb begin
      logic                          any;
      logic [rbi_pkg::DistWidth-1:0] best;
      any  = 1'b0;
      best = '0;
      for (int p = 0; p < 3; p++) begin
         if (pv_ff[p] && (!any || (pt_ff[p] < best))) begin
            best = pt_ff[p];
         end
         any = any || pv_ff[p];
      end
      rsp_new.hit      = inside_min_ff || any;
      rsp_new.distance = (inside_min_ff || !any) ? '0 : best;
   end

   // ------------------------------------------------------------------
   // Output register and skid register.
   // ------------------------------------------------------------------
   assign take     = rsp_valid_ff && !rsp_stall;
   assign new_word = adv && v_ff[StMin];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else if (take || !rsp_valid_ff) begin
         if (skid_v_ff) begin
            rsp_valid_ff <= 1'b1;
            skid_v_ff    <= 1'b0;
         end else begin
            rsp_valid_ff <= new_word;
         end
      end else if (new_word) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take || !rsp_valid_ff) begin
         if (skid_v_ff) begin
            rsp_word_ff <= skid_word_ff;
         end else begin
            rsp_word_ff <= rsp_new;
         end
      end else if (new_word) begin
         skid_word_ff <= rsp_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `ASSERT_SAME(a_skid_behind_out, clock, reset, skid_v_ff, rsp_valid_ff, "skid full with output empty")
   `ASSERT_SAME(a_skid_fill, clock, reset, $rose(skid_v_ff), $past(rsp_valid_ff && rsp_stall), "skid filled without a stall")
   `ASSERT_NEXT(a_skid_drain, clock, reset, skid_v_ff && !rsp_stall, !skid_v_ff, "skid did not drain")
   `ASSERT_SAME(a_dist_needs_hit, clock, reset, rsp_valid_ff && (rsp_word_ff.distance != '0), rsp_word_ff.hit, "distance on a miss")

endmodule

[dv/tb_ray_box_intersect_core.sv]
`timescale 1ns / 1ps

module tb_ray_box_intersect_core;

   // Rough pipeline depth of the core, padded so a word that is still in
   // flight is always seen before the box changes or the run ends.
   localparam int PipeDrain = 40;
   localparam int RandomItems = 900;

   // Bus byte addresses of the six bound registers follow their index.
   typedef enum int {
      REG_MIN_X = rbi_pkg::BoxMinBase, REG_MIN_Y, REG_MIN_Z,
      REG_MAX_X = rbi_pkg::BoxMaxBase, REG_MAX_Y, REG_MAX_Z
   } box_reg_index_type;

   typedef struct {
      rbi_pkg::req_word_type ray;
      bit                    known;
      rbi_pkg::rsp_word_type want;
   } ray_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   rbi_pkg::req_word_type            req_word;
   logic                             rsp_valid;
   logic                             rsp_stall;
   rbi_pkg::rsp_word_type            rsp_word;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [rbi_pkg::CsrAddrWidth-1:0] paddr;
   logic [rbi_pkg::CsrDataWidth-1:0] pwdata;
   logic [rbi_pkg::CsrDataWidth-1:0] prdata;
   logic                             pready;

   // The testbench's own copy of the box, sign-extended for the predictor.
   longint                box_lo [3];
   longint                box_hi [3];
   // Words still owed by the core, oldest first.
   rbi_pkg::rsp_word_type hit_queue [$];
   // Per sent word: whether the table gave the answer, and that answer.
   ray_row_type           sent_rows [$];
   ray_row_type           ray_table [$];
   int                    error_count;
   bit                    rsp_idle_on;

   ray_box_intersect_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Exact test of a*b > c*e; operands fit 34 bits, so 68 bits never overflow.
   function automatic bit cross_gt(longint a, longint b, longint c, longint e);
      logic signed [67:0] xa, xb, xc, xe;
      xa = a;
      xb = b;
      xc = c;
      xe = e;
      return (xa * xb) > (xc * xe);
   endfunction

   // Per-face test of one ray against the current box, nearest face wins.
   function automatic rbi_pkg::rsp_word_type ray_hit(rbi_pkg::req_word_type w);
      longint                o [3];
      longint                d [3];
      longint                n, dd;
      logic [63:0]           q;
      logic [31:0]           t;
      bit                    ok;
      rbi_pkg::rsp_word_type r;
      o[0] = w.origin_x;
      o[1] = w.origin_y;
      o[2] = w.origin_z;
      d[0] = w.dir_x;
      d[1] = w.dir_y;
      d[2] = w.dir_z;
      r = '0;
      if (o[0] > box_lo[0] && o[0] < box_hi[0] && o[1] > box_lo[1] && o[1] < box_hi[1] &&
          o[2] > box_lo[2] && o[2] < box_hi[2]) begin
         r.hit = 1'b1;
         return r;
      end
      for (int k = 0; k < 3; k++) begin
         for (int side = 0; side < 2; side++) begin
            if (side == 0) begin
               if (!(o[k] <= box_lo[k] && d[k] > 0)) continue;
               n  = box_lo[k] - o[k];
               dd = d[k];
            end else begin
               if (!(o[k] >= box_hi[k] && d[k] < 0)) continue;
               n  = o[k] - box_hi[k];
               dd = -d[k];
            end
            ok = 1'b1;
            for (int a = 0; a < 3; a++) begin
               if (a == k) continue;
               // The hit point on the other axis must sit inside [lo, hi].
               if (cross_gt(box_lo[a] - o[a], dd, d[a], n)) ok = 1'b0;
               if (cross_gt(d[a], n, box_hi[a] - o[a], dd)) ok = 1'b0;
            end
            if (!ok) continue;
            q = ((64'(n)) << 16) / 64'(dd);
            t = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            if (!r.hit || t < r.distance) begin
               r.hit      = 1'b1;
               r.distance = t;
            end
         end
      end
      return r;
   endfunction

   // Input side: predict every accepted word, or take the table's answer.
   always @(posedge clock) begin
      ray_row_type row;
      if (!reset && req_valid && !req_stall) begin
         row = sent_rows.pop_front();
         if (row.known) hit_queue.push_back(row.want);
         else hit_queue.push_back(ray_hit(req_word));
      end
   end

   // Output side: each accepted word is checked against the oldest expectation.
   always @(posedge clock) begin
      rbi_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hit_queue.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual hit=%0b distance=%h",
                     $time, rsp_word.hit, rsp_word.distance);
            error_count++;
         end else begin
            want = hit_queue.pop_front();
            if (rsp_word.hit !== want.hit) begin
               $display("%0t: hit mismatch, expected %0b, actual %0b",
                        $time, want.hit, rsp_word.hit);
               error_count++;
            end
            if (rsp_word.distance !== want.distance) begin
               $display("%0t: distance mismatch, expected %h, actual %h",
                        $time, want.distance, rsp_word.distance);
               error_count++;
            end
         end
      end
   end

   // Receiver: a random stall before each word, with quiet stretches set by the
   // stimulus. The loop ends on the edge that takes a word.
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         n = rsp_idle_on ? $urandom_range(0, 12) : 0;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Sends one word after a random gap; returns on the accepting edge with valid
   // still high, so back-to-back words never drop valid.
   task automatic send_ray(ray_row_type row, bit idle_on);
      int gap;
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      sent_rows.push_back(row);
      req_valid <= 1'b1;
      req_word  <= row.ray;
      do @(posedge clock); while (req_stall);
   endtask

   // Two-phase bus write followed by a readback of the same register.
   task automatic write_bound(box_reg_index_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= rbi_pkg::CsrAddrWidth'(4 * idx);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== value) begin
         $display("%0t: readback mismatch at register %0d, expected %h, actual %h",
                  $time, idx, value, prdata);
         error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (idx >= rbi_pkg::BoxMaxBase) box_hi[idx - rbi_pkg::BoxMaxBase] = longint'(signed'(value));
      else box_lo[idx - rbi_pkg::BoxMinBase] = longint'(signed'(value));
   endtask

   // The box only changes once every owed word is back and the pipe has emptied.
   task automatic load_box(longint lx, longint ly, longint lz, longint hx, longint hy,
                           longint hz);
      req_valid <= 1'b0;
      wait (hit_queue.size() == 0);
      repeat (PipeDrain) @(posedge clock);
      write_bound(REG_MIN_X, 32'(lx));
      write_bound(REG_MIN_Y, 32'(ly));
      write_bound(REG_MIN_Z, 32'(lz));
      write_bound(REG_MAX_X, 32'(hx));
      write_bound(REG_MAX_Y, 32'(hy));
      write_bound(REG_MAX_Z, 32'(hz));
   endtask

   function automatic void add_row(longint ox, longint oy, longint oz, longint dx,
                                   longint dy, longint dz, bit known, bit hit,
                                   logic [31:0] want_dist);
      ray_row_type row;
      row.ray       = {32'(ox), 32'(oy), 32'(oz), 32'(dx), 32'(dy), 32'(dz)};
      row.known     = known;
      row.want.hit  = hit;
      row.want.distance = want_dist;
      ray_table.push_back(row);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
   endfunction

   function automatic longint rand32();
      return longint'(signed'(32'($urandom)));
   endfunction

   // Most rays are aimed at a point of the box from an offset origin so that faces are
   // actually tried; the rest are raw noise or aimed rays with components zeroed at random.
   function automatic ray_row_type random_ray();
      ray_row_type row;
      longint      o [3];
      longint      d [3];
      longint      tgt, span;
      int          kind;
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
         if (kind == 0) begin
            o[k] = rand32();
            d[k] = rand32();
         end else begin
            span = box_hi[k] - box_lo[k] + 1;
            if (span > 0)
               tgt = box_lo[k] + longint'({$urandom, $urandom} % 64'(span));
            else tgt = box_lo[k];
            o[k] = clamp32(tgt + (rand32() >>> $urandom_range(4, 30)));
            // Sometimes the origin lies exactly on a face plane.
            case ($urandom_range(0, 7))
               0: o[k] = box_lo[k];
               1: o[k] = box_hi[k];
               default: ;
            endcase
            d[k] = clamp32((tgt - o[k]) >>> $urandom_range(0, 6));
            if (kind == 1 && $urandom_range(0, 1) == 1) d[k] = 0;
         end
      end
      row.ray = {32'(o[0]), 32'(o[1]), 32'(o[2]), 32'(d[0]), 32'(d[1]), 32'(d[2])};
      row.known = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   initial begin
      ray_row_type row;
      bit          idle_on;
      int          phase;
      error_count = 0;
      rsp_idle_on = 1'b1;
      box_lo      = '{0, 0, 0};
      box_hi      = '{0, 0, 0};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_word    = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First row runs against the box as reset left it: a zero ray misses.
      add_row(0, 0, 0, 0, 0, 0, 1, 0, 0);
      // The rest run against the unit box [-1, 1] on every axis.
      add_row(0, 0, 0, 0, 0, 0, 1, 1, 0);
      add_row(-32'sh20000, 0, 0, 32'sh10000, 0, 0, 1, 1, 32'h10000);
      add_row(32'sh30000, 0, 0, -32'sh10000, 0, 0, 1, 1, 32'h20000);
      add_row(0, -32'sh20000, 0, 0, 32'sh10000, 0, 1, 1, 32'h10000);
      add_row(0, 0, 32'sh20000, 0, 0, -32'sh20000, 1, 1, 32'h8000);
      add_row(-32'sh20000, 0, 0, 0, 0, 0, 1, 0, 0);
      add_row(-32'sh20000, 0, 0, -32'sh10000, 0, 0, 1, 0, 0);
      // A tiny step from far away overflows the distance and saturates.
      add_row(-64'sh8000_0000, 0, 0, 1, 0, 0, 1, 1, 32'hFFFF_FFFF);
      // Origin on a face plane, grazing edges, and full-scale fields.
      add_row(-32'sh10000, 0, 0, 32'sh10000, 0, 0, 0, 0, 0);
      add_row(-32'sh20000, -32'sh20000, 0, 32'sh10000, 32'sh10000, 0, 0, 0, 0);
      add_row(-32'sh20000, 32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0, 0, 0);
      add_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -64'sh8000_0000,
              -64'sh8000_0000, -64'sh8000_0000, 0, 0, 0);
      add_row(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0);
      add_row(32'sh7FFF_FFFF, 0, 0, -1, 0, 0, 0, 0, 0);
      add_row(-32'sh20000, -32'sh30000, 32'sh30000, 32'sh10000, 32'sh10000,
              -32'sh10000, 0, 0, 0);

      foreach (ray_table[i]) begin
         if (i == 1) load_box(-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000,
                              32'sh10000, 32'sh10000);
         send_ray(ray_table[i], 1'b1);
      end

      // Random phases, each with its own box: full range, a box inverted on x,
      // a flat box, the unit box, and two random boxes.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_box(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
            1: load_box(32'sh10000, -32'sh40000, -32'sh40000, -32'sh10000, 32'sh40000,
                        32'sh40000);
            2: load_box(-32'sh30000, 32'sh20000, -32'sh50000, 32'sh30000, 32'sh20000,
                        32'sh50000);
            3: load_box(-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000,
                        32'sh10000);
            default: load_box(-longint'($urandom_range(0, 32'h0100_0000)),
                              -longint'($urandom_range(0, 32'h0100_0000)),
                              -longint'($urandom_range(0, 32'h0100_0000)),
                              longint'($urandom_range(0, 32'h0100_0000)),
                              longint'($urandom_range(0, 32'h0100_0000)),
                              longint'($urandom_range(0, 32'h0100_0000)));
         endcase
         for (int i = 0; i < RandomItems / 6; i++) begin
            // Every fifty words both sides pick anew, at random, between idling and full rate.
            if (i % 50 == 0) begin
               idle_on     = $urandom_range(0, 2) != 0;
               rsp_idle_on = $urandom_range(0, 2) != 0;
            end
            row = random_ray();
            send_ray(row, idle_on);
         end
      end

      req_valid   <= 1'b0;
      rsp_idle_on = 1'b1;
      wait (hit_queue.size() == 0);
      repeat (PipeDrain) @(posedge clock);
      if (error_count == 0 && hit_queue.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
